// File: src/dam_pkg.sv
// Package: fixed widths, constants and the arctangent table of the dihedral angle pipeline.
`default_nettype none

package dam_pkg;

  // result width and fixed internal precisions
  localparam int ANGLE_W      = 15;
  localparam int NORM_BITS    = 15;
  localparam int N_W          = NORM_BITS + 1;
  localparam int CORDIC_STEPS = 24;
  localparam int ACC_FRAC     = 20;
  localparam int SQRT_STEPS   = 32;
  localparam int DOT_W        = 2 * N_W + 2;
  localparam int CRS_W        = 2 * N_W + 1;
  localparam int XY_W         = 33;
  localparam int XY_LEN_W     = 6;
  localparam int CX_W         = 62;
  localparam int Z_W          = 30;
  localparam int NORM_TOP     = 58;
  localparam int TAB_W        = 27;

  // atan(2^-i) in units of 2^-20 degree
  localparam logic [TAB_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121, 27'd3750058, 27'd1876857,
    27'd938658,   27'd469357,   27'd234682,   27'd117342,  27'd58671,   27'd29335,
    27'd14668,    27'd7334,     27'd3667,     27'd1833,    27'd917,     27'd458,
    27'd229,      27'd115,      27'd57,       27'd29,      27'd14,      27'd7
  };

  localparam logic [Z_W-1:0] Z_LIM  = Z_W'(90 << ACC_FRAC);
  localparam logic [Z_W-1:0] Z_HALF = Z_W'(180 << ACC_FRAC);

endpackage

`default_nettype wire

// File: src/dihedral_angle_measure.sv
// Top level: pipelined unsigned dihedral angle of four atoms.
//
// Usage: drive the twelve atom coordinates and raise start_i; the word is
// taken at every rising edge with start_i high, and busy_o stays low, so a
// new quadruple may enter in every cycle.
// The result appears on angle_degrees_o and degenerate_o for exactly one
// cycle, marked by done_o. Throughput is one word per cycle; every step
// sits in its own register stage: differences, cross products, normal
// scaling (search, shift), dot and cross of the scaled normals, squares,
// a 32 stage integer square root, operand normalisation and a 24 stage
// CORDIC, then rounding. The deepest stages hold one 33x33 multiply or
// one 66 bit compare/subtract.
// A zero normal gives degenerate_o high and an angle of 0.
// Reset clears all valid bits, so no done_o strobe follows reset until
// new words have passed through. The receiver cannot stall; the pipeline
// never holds.
`default_nettype none

module dihedral_angle_measure #(
  parameter int COORD_WIDTH     = 24,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic signed [COORD_WIDTH-1:0] atom1_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] atom1_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] atom1_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] atom2_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] atom2_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] atom2_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] atom3_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] atom3_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] atom3_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] atom4_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] atom4_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] atom4_z_i,
  output logic                               done_o,
  output logic [dam_pkg::ANGLE_W-1:0]        angle_degrees_o,
  output logic                               degenerate_o
);

  import dam_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int XW = PW + 1;
  localparam int LW = $clog2(XW + 1);
  localparam int RND_SH = ACC_FRAC - ANGLE_FRAC_BITS;

  assign busy_o = 1'b0;

  // valid bits of the front stages
  logic [9:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[8:0], start_i};
    end
  end

  // stage 1: difference vectors relative to atom 3
  logic signed [DW-1:0] a1_q [3], a2_q [3], a4_q [3];
  logic signed [DW-1:0] a1_d [3], a2_d [3], a4_d [3];
  logic signed [COORD_WIDTH-1:0] c1 [3], c2 [3], c3 [3], c4 [3];
  always_comb begin
    c1[0] = atom1_x_i; c1[1] = atom1_y_i; c1[2] = atom1_z_i;
    c2[0] = atom2_x_i; c2[1] = atom2_y_i; c2[2] = atom2_z_i;
    c3[0] = atom3_x_i; c3[1] = atom3_y_i; c3[2] = atom3_z_i;
    c4[0] = atom4_x_i; c4[1] = atom4_y_i; c4[2] = atom4_z_i;
    for (int j = 0; j < 3; j++) begin
      a1_d[j] = DW'(c1[j]) - DW'(c3[j]);
      a2_d[j] = DW'(c2[j]) - DW'(c3[j]);
      a4_d[j] = DW'(c4[j]) - DW'(c3[j]);
    end
  end
  always_ff @(posedge clk_i) begin
    a1_q <= a1_d; a2_q <= a2_d; a4_q <= a4_d;
  end

  // stage 2: the twelve partial products of both cross products
  logic signed [PW-1:0] pa_q [6], pb_q [6];
  always_ff @(posedge clk_i) begin
    pa_q[0] <= a1_q[1] * a2_q[2]; pa_q[1] <= a1_q[2] * a2_q[1];
    pa_q[2] <= a1_q[2] * a2_q[0]; pa_q[3] <= a1_q[0] * a2_q[2];
    pa_q[4] <= a1_q[0] * a2_q[1]; pa_q[5] <= a1_q[1] * a2_q[0];
    pb_q[0] <= a4_q[1] * a2_q[2]; pb_q[1] <= a4_q[2] * a2_q[1];
    pb_q[2] <= a4_q[2] * a2_q[0]; pb_q[3] <= a4_q[0] * a2_q[2];
    pb_q[4] <= a4_q[0] * a2_q[1]; pb_q[5] <= a4_q[1] * a2_q[0];
  end

  // stage 3: exact normals
  logic signed [XW-1:0] w1_q [3], w2_q [3];
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      w1_q[j] <= XW'(pa_q[2*j]) - XW'(pa_q[2*j+1]);
      w2_q[j] <= XW'(pb_q[2*j]) - XW'(pb_q[2*j+1]);
    end
  end

  // stage 4: sign and magnitude of each component
  logic [XW-1:0] m1_q [3], m2_q [3];
  logic [2:0]    s1_q, s2_q;
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      s1_q[j] <= w1_q[j][XW-1];
      s2_q[j] <= w2_q[j][XW-1];
      m1_q[j] <= w1_q[j][XW-1] ? XW'(-w1_q[j]) : XW'(w1_q[j]);
      m2_q[j] <= w2_q[j][XW-1] ? XW'(-w2_q[j]) : XW'(w2_q[j]);
    end
  end

  // stage 5: bit length of each normal
  logic [XW-1:0] m1b_q [3], m2b_q [3];
  logic [2:0]    s1b_q, s2b_q;
  logic [LW-1:0] l1_q, l2_q, l1_d, l2_d;
  logic [XW-1:0] or1, or2;
  always_comb begin
    or1  = m1_q[0] | m1_q[1] | m1_q[2];
    or2  = m2_q[0] | m2_q[1] | m2_q[2];
    l1_d = '0;
    l2_d = '0;
    for (int i = 0; i < XW; i++) begin
      if (or1[i]) l1_d = LW'(i + 1);
      if (or2[i]) l2_d = LW'(i + 1);
    end
  end
  always_ff @(posedge clk_i) begin
    m1b_q <= m1_q; m2b_q <= m2_q;
    s1b_q <= s1_q; s2b_q <= s2_q;
    l1_q  <= l1_d; l2_q  <= l2_d;
  end

  // stage 6: scale both normals below 2^NORM_BITS
  logic signed [N_W-1:0] n1_q [3], n2_q [3], n1_d [3], n2_d [3];
  logic                  dg6_q;
  logic [LW-1:0]         sh1, sh2;
  logic [XW-1:0]         t1, t2;
  always_comb begin
    sh1 = (l1_q > LW'(NORM_BITS)) ? l1_q - LW'(NORM_BITS) : '0;
    sh2 = (l2_q > LW'(NORM_BITS)) ? l2_q - LW'(NORM_BITS) : '0;
    for (int j = 0; j < 3; j++) begin
      t1 = m1b_q[j] >> sh1;
      t2 = m2b_q[j] >> sh2;
      n1_d[j] = s1b_q[j] ? -$signed({1'b0, t1[NORM_BITS-1:0]})
                         :  $signed({1'b0, t1[NORM_BITS-1:0]});
      n2_d[j] = s2b_q[j] ? -$signed({1'b0, t2[NORM_BITS-1:0]})
                         :  $signed({1'b0, t2[NORM_BITS-1:0]});
    end
  end
  always_ff @(posedge clk_i) begin
    n1_q  <= n1_d;
    n2_q  <= n2_d;
    dg6_q <= (l1_q == '0) || (l2_q == '0);
  end

  // stage 7: products for dot and cross of the scaled normals
  logic signed [2*N_W-1:0] pd_q [3], pc_q [6];
  logic                    dg7_q;
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) pd_q[j] <= n1_q[j] * n2_q[j];
    pc_q[0] <= n1_q[1] * n2_q[2]; pc_q[1] <= n1_q[2] * n2_q[1];
    pc_q[2] <= n1_q[2] * n2_q[0]; pc_q[3] <= n1_q[0] * n2_q[2];
    pc_q[4] <= n1_q[0] * n2_q[1]; pc_q[5] <= n1_q[1] * n2_q[0];
    dg7_q   <= dg6_q;
  end

  // stage 8: dot product and cross components
  logic signed [DOT_W-1:0] dot_q;
  logic signed [CRS_W-1:0] cr_q [3];
  logic                    dg8_q;
  always_ff @(posedge clk_i) begin
    dot_q <= DOT_W'(pd_q[0]) + DOT_W'(pd_q[1]) + DOT_W'(pd_q[2]);
    for (int j = 0; j < 3; j++) cr_q[j] <= CRS_W'(pc_q[2*j]) - CRS_W'(pc_q[2*j+1]);
    dg8_q <= dg7_q;
  end

  // stage 9: squares of the cross components, magnitude of the dot
  logic [63:0]       q_q [3];
  logic [XY_W-1:0]   dm9_q;
  logic              dn9_q, dg9_q;
  logic [CRS_W-1:0]  cm [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cm[j] = cr_q[j][CRS_W-1] ? CRS_W'(-cr_q[j]) : CRS_W'(cr_q[j]);
    end
  end
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) q_q[j] <= 64'(cm[j]) * 64'(cm[j]);
    dn9_q <= dot_q[DOT_W-1];
    dm9_q <= dot_q[DOT_W-1] ? XY_W'(-dot_q) : XY_W'(dot_q);
    dg9_q <= dg8_q;
  end

  // stage 10 and square root stages: remainder and root per stage
  logic [63:0]     rem_q  [SQRT_STEPS+1];
  logic [31:0]     root_q [SQRT_STEPS+1];
  logic [XY_W-1:0] sdm_q  [SQRT_STEPS+1];
  logic            sdn_q  [SQRT_STEPS+1];
  logic            sdg_q  [SQRT_STEPS+1];
  logic [SQRT_STEPS:0] sv_q;

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= q_q[0] + q_q[1] + q_q[2];
    root_q[0] <= '0;
    sdm_q[0]  <= dm9_q;
    sdn_q[0]  <= dn9_q;
    sdg_q[0]  <= dg9_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
    end else begin
      sv_q <= {sv_q[SQRT_STEPS-1:0], vld_q[9]};
    end
  end

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    localparam int K = SQRT_STEPS - 1 - g;
    logic [65:0] term;
    logic        take;
    assign term = ({34'd0, root_q[g]} << (K + 1)) + (66'd1 << (2 * K));
    assign take = {2'b00, rem_q[g]} >= term;
    always_ff @(posedge clk_i) begin
      rem_q[g+1]  <= take ? 64'({2'b00, rem_q[g]} - term) : rem_q[g];
      root_q[g+1] <= take ? (root_q[g] | (32'd1 << K)) : root_q[g];
      sdm_q[g+1]  <= sdm_q[g];
      sdn_q[g+1]  <= sdn_q[g];
      sdg_q[g+1]  <= sdg_q[g];
    end
  end

  // normalise stage A: bit length of x | y
  logic [XY_W-1:0]     nx_q, ny_q, nor_v;
  logic [XY_LEN_W-1:0] nl_q, nl_d;
  logic                nn_q, ng_q, nv_q;
  always_comb begin
    nor_v = sdm_q[SQRT_STEPS] | XY_W'(root_q[SQRT_STEPS]);
    nl_d  = '0;
    for (int i = 0; i < XY_W; i++) begin
      if (nor_v[i]) nl_d = XY_LEN_W'(i + 1);
    end
  end
  always_ff @(posedge clk_i) begin
    nx_q <= sdm_q[SQRT_STEPS];
    ny_q <= XY_W'(root_q[SQRT_STEPS]);
    nl_q <= nl_d;
    nn_q <= sdn_q[SQRT_STEPS];
    ng_q <= sdg_q[SQRT_STEPS];
  end

  // CORDIC stage registers; index 0 is normalise stage B
  logic signed [CX_W-1:0] cx_q [CORDIC_STEPS+1];
  logic signed [CX_W-1:0] cy_q [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  cz_q [CORDIC_STEPS+1];
  logic                   cn_q [CORDIC_STEPS+1];
  logic                   cg_q [CORDIC_STEPS+1];
  logic                   c0_q [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0]  cv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= 1'b0;
      cv_q <= '0;
    end else begin
      nv_q <= sv_q[SQRT_STEPS];
      cv_q <= {cv_q[CORDIC_STEPS-1:0], nv_q};
    end
  end

  // normalise stage B: top bit of x | y to bit NORM_TOP-1
  logic [XY_LEN_W-1:0] nsh;
  assign nsh = XY_LEN_W'(NORM_TOP) - nl_q;
  always_ff @(posedge clk_i) begin
    cx_q[0] <= $signed(CX_W'(nx_q) << nsh);
    cy_q[0] <= $signed(CX_W'(ny_q) << nsh);
    cz_q[0] <= '0;
    cn_q[0] <= nn_q;
    cg_q[0] <= ng_q;
    c0_q[0] <= (nl_q == '0);
  end

  // vectoring CORDIC, one rotation per stage
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    logic signed [CX_W-1:0] dx, dy;
    logic signed [Z_W-1:0]  at;
    assign dx = cy_q[g] >>> g;
    assign dy = cx_q[g] >>> g;
    assign at = $signed(Z_W'(ATAN_TAB[g]));
    always_ff @(posedge clk_i) begin
      if (!cy_q[g][CX_W-1]) begin
        cx_q[g+1] <= cx_q[g] + dx;
        cy_q[g+1] <= cy_q[g] - dy;
        cz_q[g+1] <= cz_q[g] + at;
      end else begin
        cx_q[g+1] <= cx_q[g] - dx;
        cy_q[g+1] <= cy_q[g] + dy;
        cz_q[g+1] <= cz_q[g] - at;
      end
      cn_q[g+1] <= cn_q[g];
      cg_q[g+1] <= cg_q[g];
      c0_q[g+1] <= c0_q[g];
    end
  end

  // output stage: clamp, quadrant fold, round half up
  logic signed [Z_W-1:0] zf;
  logic [Z_W-1:0]        zc, af, ar;
  logic [ANGLE_W-1:0]    ang_q;
  logic                  deg_q;
  always_comb begin
    zf = cz_q[CORDIC_STEPS];
    if (c0_q[CORDIC_STEPS] || zf[Z_W-1]) begin
      zc = '0;
    end else if (zf > $signed(Z_LIM)) begin
      zc = Z_LIM;
    end else begin
      zc = zf;
    end
    af = cn_q[CORDIC_STEPS] ? Z_HALF - zc : zc;
    ar = (af + (Z_W'(1) << (RND_SH - 1))) >> RND_SH;
  end
  always_ff @(posedge clk_i) begin
    deg_q <= cg_q[CORDIC_STEPS];
    ang_q <= cg_q[CORDIC_STEPS] ? '0 : ar[ANGLE_W-1:0];
  end

  // the last valid bit lines up with the output registers
  assign done_o          = cv_q[CORDIC_STEPS];
  assign angle_degrees_o = ang_q;
  assign degenerate_o    = deg_q;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Testbench: random and directed atom quadruples through the dihedral angle pipeline.
`timescale 1ns / 100ps

module tb_top;
  import dam_pkg::*;

  localparam int CW        = 24;
  localparam int N_RANDOM  = 640;
  localparam int IDLE_MAX  = 3000;
  localparam int TAIL_CYC  = 120;
  localparam int AFRAC     = 7;
  localparam longint CMAX  = 8388607;
  localparam longint CMIN  = -8388608;

  typedef struct packed {
    logic [11:0][CW-1:0] crd;
    logic                drain;
  } quad_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               degen;
  } angle_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_r = 1'b0;
  logic [11:0][CW-1:0] crd_r = '0;
  logic busy_o, done_o, degenerate_o;
  logic [ANGLE_W-1:0] angle_degrees_o;

  quad_t  pend_q[$];
  angle_t angle_q[$];
  int     errors = 0;
  int     sent = 0;
  int     gap_cnt = 0;
  int     idle_cnt = 0;
  bit     drain_hold = 1'b0;

  dihedral_angle_measure dut (
    .clk_i, .rst_ni, .start_i(start_r), .busy_o,
    .atom1_x_i(crd_r[0]), .atom1_y_i(crd_r[1]), .atom1_z_i(crd_r[2]),
    .atom2_x_i(crd_r[3]), .atom2_y_i(crd_r[4]), .atom2_z_i(crd_r[5]),
    .atom3_x_i(crd_r[6]), .atom3_y_i(crd_r[7]), .atom3_z_i(crd_r[8]),
    .atom4_x_i(crd_r[9]), .atom4_y_i(crd_r[10]), .atom4_z_i(crd_r[11]),
    .done_o, .angle_degrees_o, .degenerate_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // append a word to the pending queue
  function automatic void queue_word(input quad_t q);
    pend_q = {pend_q, q};
  endfunction

  function automatic int bit_len(input logic [63:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 64; i++) if (v[i]) n = i + 1;
    return n;
  endfunction

  // scale a normal until each component fits NORM_BITS; 0 when the normal is null
  function automatic bit scale_normal(input longint w [3], output longint n [3]);
    logic [63:0] m [3];
    logic [63:0] orv;
    int len, s;
    orv = '0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (w[i] < 0) ? -w[i] : w[i];
      orv |= m[i];
    end
    len = bit_len(orv);
    s = (len > NORM_BITS) ? len - NORM_BITS : 0;
    for (int i = 0; i < 3; i++) begin
      n[i] = longint'(m[i] >> s);
      if (w[i] < 0) n[i] = -n[i];
    end
    return len != 0;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, b;
    res = '0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // vectoring CORDIC, angle in 2^-20 degree, clamped to a quarter turn
  function automatic longint atan_vec(input logic [63:0] x, input logic [63:0] y);
    longint xa, ya, z, dx, dy;
    int sh;
    if ((x | y) == 0) return 0;
    sh = 58 - bit_len(x | y);
    if (sh < 0) sh = 0;
    xa = longint'(x << sh);
    ya = longint'(y << sh);
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = ya >>> i;
      dy = xa >>> i;
      if (ya >= 0) begin
        xa += dx; ya -= dy; z += longint'(ATAN_TAB[i]);
      end else begin
        xa -= dx; ya += dy; z -= longint'(ATAN_TAB[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > (longint'(90) << ACC_FRAC)) z = longint'(90) << ACC_FRAC;
    return z;
  endfunction

  function automatic angle_t dihedral(input logic [11:0][CW-1:0] c);
    longint p [4][3];
    longint a [3], b [3], d3 [3], w1 [3], w2 [3], n1 [3], n2 [3], cr [3];
    longint dot, ang;
    logic [63:0] sq, mg;
    angle_t r;
    for (int i = 0; i < 12; i++) p[i/3][i%3] = longint'($signed(c[i]));
    for (int j = 0; j < 3; j++) begin
      a[j] = p[0][j] - p[2][j];
      b[j] = p[1][j] - p[2][j];
      d3[j] = p[3][j] - p[2][j];
    end
    w1[0] = a[1]*b[2] - a[2]*b[1];   w2[0] = d3[1]*b[2] - d3[2]*b[1];
    w1[1] = a[2]*b[0] - a[0]*b[2];   w2[1] = d3[2]*b[0] - d3[0]*b[2];
    w1[2] = a[0]*b[1] - a[1]*b[0];   w2[2] = d3[0]*b[1] - d3[1]*b[0];
    r = '0;
    if (!scale_normal(w1, n1) || !scale_normal(w2, n2)) begin
      r.degen = 1'b1;
      return r;
    end
    dot = n1[0]*n2[0] + n1[1]*n2[1] + n1[2]*n2[2];
    cr[0] = n1[1]*n2[2] - n1[2]*n2[1];
    cr[1] = n1[2]*n2[0] - n1[0]*n2[2];
    cr[2] = n1[0]*n2[1] - n1[1]*n2[0];
    sq = '0;
    for (int j = 0; j < 3; j++) begin
      mg = (cr[j] < 0) ? -cr[j] : cr[j];
      sq += mg * mg;
    end
    mg = (dot < 0) ? -dot : dot;
    ang = atan_vec(mg, int_sqrt(sq));
    if (dot < 0) ang = (longint'(180) << ACC_FRAC) - ang;
    ang = (ang + (longint'(1) << (ACC_FRAC - 1 - AFRAC))) >>> (ACC_FRAC - AFRAC);
    r.angle = ANGLE_W'(ang);
    return r;
  endfunction

  function automatic quad_t mk(input longint v [12]);
    quad_t q;
    q = '0;
    for (int i = 0; i < 12; i++) q.crd[i] = CW'(v[i]);
    return q;
  endfunction

  // mostly well-formed quadruples around a centre, some noise and null normals
  function automatic quad_t rand_quad();
    quad_t q;
    longint ctr [3];
    longint off;
    int kind, k, src;
    q = '0;
    kind = $urandom_range(0, 99);
    for (int j = 0; j < 3; j++) ctr[j] = longint'($signed(CW'($urandom())));
    for (int i = 0; i < 12; i++) begin
      if (kind < 12) begin
        q.crd[i] = CW'($urandom());
      end else begin
        k = $urandom_range(1, 23);
        off = longint'($urandom_range(0, (1 << k) - 1)) - (longint'(1) << (k - 1));
        q.crd[i] = CW'(ctr[i%3] + off);
      end
    end
    if (kind >= 12 && kind < 17) begin
      // coincident atoms: copy one atom onto another
      src = $urandom_range(0, 3);
      k = $urandom_range(0, 3);
      for (int j = 0; j < 3; j++) q.crd[k*3+j] = q.crd[src*3+j];
    end else if (kind >= 17 && kind < 20) begin
      // atom four on the central bond line
      for (int j = 0; j < 3; j++) q.crd[9+j] = CW'(2*$signed(q.crd[3+j]) - $signed(q.crd[6+j]));
    end
    return q;
  endfunction

  // driver: present pending words, random gaps, one drain pause
  always @(posedge clk_i) begin
    if (start_r && !busy_o) begin
      angle_q = {angle_q, dihedral(crd_r)};
      sent <= sent + 1;
    end
    if (!rst_ni) begin
      start_r <= 1'b0;
    end else if (start_r && busy_o) begin
      start_r <= 1'b1;
    end else if (gap_cnt > 0) begin
      start_r <= 1'b0;
      gap_cnt <= gap_cnt - 1;
    end else if (pend_q.size() > 0 && pend_q[0].drain && angle_q.size() != 0) begin
      start_r <= 1'b0;
    end else if (pend_q.size() > 0) begin
      crd_r <= pend_q[0].crd;
      pend_q.pop_front();
      start_r <= 1'b1;
      if (sent > 200 && sent < 320) gap_cnt <= 0;
      else if ($urandom_range(0, 9) < 6) gap_cnt <= 0;
      else if ($urandom_range(0, 9) < 8) gap_cnt <= $urandom_range(1, 3);
      else gap_cnt <= $urandom_range(5, 80);
    end else begin
      start_r <= 1'b0;
    end
  end

  // monitor: compare each result word against the oldest predicted angle
  always @(posedge clk_i) begin
    angle_t want;
    if (done_o) begin
      if (angle_q.size() == 0) begin
        $error("result word with no prediction waiting");
        errors = errors + 1;
      end else begin
        want = angle_q.pop_front();
        if (angle_degrees_o !== want.angle) begin
          $error("angle_degrees: expected %0d, got %0d", want.angle, angle_degrees_o);
          errors = errors + 1;
        end
        if (degenerate_o !== want.degen) begin
          $error("degenerate: expected %0d, got %0d", want.degen, degenerate_o);
          errors = errors + 1;
        end
      end
    end
    // watchdog on cycles with no traffic
    if (done_o || (start_r && !busy_o) || !rst_ni) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > IDLE_MAX) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    quad_t q;
    // directed words: null normals, planar, right angle, extremes
    queue_word(mk('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}));
    queue_word(mk('{5, 7, 9, 4096, 0, 0, 5, 7, 9, 0, 0, 4096}));
    queue_word(mk('{0, 4096, 0, 4096, 0, 0, 0, 0, 0, 8192, 0, 0}));
    queue_word(mk('{0, 4096, 0, 4096, 0, 0, 0, 0, 0, 4096, 4096, 0}));
    queue_word(mk('{0, 4096, 0, 4096, 0, 0, 0, 0, 0, 4096, -4096, 0}));
    queue_word(mk('{0, 4096, 0, 4096, 0, 0, 0, 0, 0, 4096, 0, 4096}));
    queue_word(mk('{0, 4096, 0, 4096, 0, 0, 0, 0, 0, 4096, 4096, 1}));
    queue_word(mk('{0, 4096, 0, 4096, 0, 0, 0, 0, 0, 4096, -4096, 1}));
    queue_word(mk('{0, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 1}));
    queue_word(mk('{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 0, 0, 0, CMAX, CMIN, CMAX}));
    queue_word(mk('{CMIN, CMIN, CMIN, CMAX, CMIN, 0, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN}));
    queue_word(mk('{CMAX, CMIN, 0, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, 0, CMAX, CMIN}));
    queue_word(mk('{9, 9, 9, 3, 3, 3, 3, 3, 3, 1, 2, 3}));
    queue_word(mk('{CMIN, 0, 0, CMAX, 0, 0, 0, 0, 0, 0, CMAX, 0}));
    for (int n = 0; n < N_RANDOM; n++) begin
      q = rand_quad();
      q.drain = (n == N_RANDOM / 2);
      queue_word(q);
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (pend_q.size() != 0 || start_r || angle_q.size() != 0);
    repeat (TAIL_CYC) @(posedge clk_i);
    if (errors == 0 && angle_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// File: dihedral_angle_measure.f
src/dam_pkg.sv
src/dihedral_angle_measure.sv
tb/tb_top.sv
